[src/distance_constraint_projection_top_defines.svh]
// Assertion macros used by the checker file of the constraint projection block.
`ifndef DISTANCE_CONSTRAINT_PROJECTION_TOP_DEFINES_SVH
`define DISTANCE_CONSTRAINT_PROJECTION_TOP_DEFINES_SVH

// Overlapping implication, disabled while reset is low.
`define DCP_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DCP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[src/dcp_pkg.sv]
// Widths, latency and pipeline context types of the constraint projection block.
`default_nettype none
package dcp_pkg;

  localparam int POS_W   = 32;              // Q16.16 position and scalar fields
  localparam int CFG_W   = 24;              // inv_dt_squared register
  localparam logic [CFG_W-1:0] CFG_RESET = 24'd3600;
  localparam int AD_W    = POS_W;           // |delta| per axis
  localparam int SQ_W    = 2 * AD_W;        // delta squared
  localparam int SUM_W   = SQ_W + 2;        // sum of three squares
  localparam int ROOT_W  = SUM_W / 2;       // distance
  localparam int ALPHA_W = POS_W + CFG_W;   // compliance * inv_dt_squared
  localparam int DEN_W   = ALPHA_W + 1;     // w_a + w_b + alpha
  localparam int ABSC_W  = ROOT_W;          // |C|
  localparam int NUM_W   = POS_W + ABSC_W;  // dividend of both divisions
  localparam int QUO_W   = ABSC_W;          // quotient of both divisions

  // accept edge to result edge
  localparam int LATENCY = 8 + ROOT_W + 2 * QUO_W;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [AD_W-1:0]         mag_t;

  // carried alongside the square root
  typedef struct packed {
    pos_t [2:0]       pos_a;
    pos_t [2:0]       pos_b;
    mag_t [2:0]       ad;
    logic [2:0]       dneg;
    logic [2:0]       dnz;
    logic [POS_W-1:0] wa;
    logic [POS_W-1:0] wb;
    logic             fa;
    logic             fb;
    logic [POS_W-1:0] rest;
    logic [DEN_W-1:0] denom;
    logic             wzero;
  } ctx_sq_t;

  // carried alongside the lambda division
  typedef struct packed {
    pos_t [2:0]        pos_a;
    pos_t [2:0]        pos_b;
    mag_t [2:0]        ad;
    logic [2:0]        dneg;
    logic [2:0]        dnz;
    logic              fa;
    logic              fb;
    logic              skip;
    logic              cneg;
    logic              cnz;
    logic [POS_W-1:0]  viol;
    logic [ROOT_W-1:0] span;
  } ctx_d1_t;

  // carried alongside the per-axis division
  typedef struct packed {
    pos_t [2:0]       pos_a;
    pos_t [2:0]       pos_b;
    logic [2:0]       dneg;
    logic [2:0]       dnz;
    logic             fa;
    logic             fb;
    logic             skip;
    logic             cneg;
    logic             cnz;
    logic [POS_W-1:0] viol;
  } ctx_d2_t;

endpackage
`default_nettype wire

[src/dcp_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module dcp_sqrt_pipe #(
  parameter int ROOT_W = dcp_pkg::ROOT_W
) (
  input  logic                  clk,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  logic [RAD_W-1:0]  rad_r    [ROOT_W];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt  [ROOT_W];

  always_comb begin
    for (int s = 0; s < ROOT_W; s++) begin
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W-1:0]  rad_in;
      logic [REM_W+1:0]  rem4;
      logic [REM_W+1:0]  trial;
      logic              ge;
      if (s == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad_i;
      end else begin
        rem_in  = rem_r[s-1];
        root_in = root_r[s-1];
        rad_in  = rad_r[s-1];
      end
      // bring down the next pair of radicand bits, try root*4+1
      rem4  = {rem_in, rad_in[RAD_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      ge    = (rem4 >= trial);
      rem_nxt[s]  = ge ? REM_W'(rem4 - trial) : rem4[REM_W-1:0];
      root_nxt[s] = {root_in[ROOT_W-2:0], ge};
      rad_nxt[s]  = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ROOT_W; s++) begin
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
      rad_r[s]  <= rad_nxt[s];
    end
  end

  assign root_o = root_r[ROOT_W-1];

endmodule
`default_nettype wire

[src/dcp_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module dcp_div_pipe #(
  parameter int NUM_W = dcp_pkg::NUM_W,
  parameter int DEN_W = dcp_pkg::DEN_W,
  parameter int QUO_W = dcp_pkg::QUO_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  // the quotient is known to fit QUO_W bits, so the top of the dividend is
  // already below the divisor and loads as the first partial remainder
  logic [DEN_W-1:0] rem_r   [QUO_W];
  logic [QUO_W-1:0] low_r   [QUO_W];
  logic [DEN_W-1:0] den_r   [QUO_W];
  logic [QUO_W-1:0] quo_r   [QUO_W];
  logic [DEN_W-1:0] rem_nxt [QUO_W];
  logic [QUO_W-1:0] low_nxt [QUO_W];
  logic [DEN_W-1:0] den_nxt [QUO_W];
  logic [QUO_W-1:0] quo_nxt [QUO_W];

  always_comb begin
    for (int s = 0; s < QUO_W; s++) begin
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] low_in;
      logic [DEN_W-1:0] den_in;
      logic [QUO_W-1:0] quo_in;
      logic [DEN_W:0]   trial;
      logic             ge;
      if (s == 0) begin
        rem_in = DEN_W'(num_i >> QUO_W);
        low_in = num_i[QUO_W-1:0];
        den_in = den_i;
        quo_in = '0;
      end else begin
        rem_in = rem_r[s-1];
        low_in = low_r[s-1];
        den_in = den_r[s-1];
        quo_in = quo_r[s-1];
      end
      trial = {rem_in, low_in[QUO_W-1]};
      ge    = (trial >= {1'b0, den_in});
      rem_nxt[s] = ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
      low_nxt[s] = low_in << 1;
      den_nxt[s] = den_in;
      quo_nxt[s] = {quo_in[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QUO_W; s++) begin
      rem_r[s] <= rem_nxt[s];
      low_r[s] <= low_nxt[s];
      den_r[s] <= den_nxt[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign quo_o = quo_r[QUO_W-1];

endmodule
`default_nettype wire

[src/distance_constraint_projection_top.sv]
// Top level of the XPBD distance constraint projection pipeline.
//
//  channel   handshake             payload
//  in_*      start / busy          two positions, inverse masses, pins, rest, compliance
//  out_*     out_valid (strobe)    two corrected positions, violation
//  cfg_*     cfg_we                cfg_wdata = inv_dt_squared
//
// One item enters per cycle while busy is low; each item passes through the
// bit-serial pipelines: 33 square root stages, 33 stages for the lambda division
// and 33 for the per-axis division, plus eight arithmetic stages. Synchronous
// reset clears the valid pipeline and loads the register with CFG_RESET; busy
// stays high from reset until the first clock edge after reset is released and
// is low from then on.
// The result strobe cannot be held off, so the pipeline never stalls.
`default_nettype none
module distance_constraint_projection_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           in_pos_a_x,
  input  logic signed [31:0]           in_pos_a_y,
  input  logic signed [31:0]           in_pos_a_z,
  input  logic signed [31:0]           in_pos_b_x,
  input  logic signed [31:0]           in_pos_b_y,
  input  logic signed [31:0]           in_pos_b_z,
  input  logic [31:0]                  in_inv_mass_a,
  input  logic [31:0]                  in_inv_mass_b,
  input  logic                         in_fixed_a,
  input  logic                         in_fixed_b,
  input  logic [31:0]                  in_rest_length,
  input  logic [31:0]                  in_compliance,
  input  logic                         cfg_we,
  input  logic [23:0]                  cfg_wdata,
  output logic                         out_valid,
  output logic signed [31:0]           out_new_a_x,
  output logic signed [31:0]           out_new_a_y,
  output logic signed [31:0]           out_new_a_z,
  output logic signed [31:0]           out_new_b_x,
  output logic signed [31:0]           out_new_b_y,
  output logic signed [31:0]           out_new_b_z,
  output logic [31:0]                  out_violation
);

  localparam int POS_W   = dcp_pkg::POS_W;
  localparam int ROOT_W  = dcp_pkg::ROOT_W;
  localparam int QUO_W   = dcp_pkg::QUO_W;
  localparam int NUM_W   = dcp_pkg::NUM_W;
  localparam int LATENCY = dcp_pkg::LATENCY;

  // saturate a widened sum into the signed position range
  function automatic dcp_pkg::pos_t sat_pos(input logic [POS_W+2:0] v);
    logic fits;
    fits = (v[POS_W+2:POS_W-1] == '0) || (v[POS_W+2:POS_W-1] == '1);
    if (fits) begin
      return v[POS_W-1:0];
    end else if (v[POS_W+2]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  // ---------------- control: register, busy, valid line ----------------
  logic [dcp_pkg::CFG_W-1:0] inv_dt_sq_r;
  logic                      busy_r;
  logic [LATENCY-1:0]        vld_r;
  logic                      accept;

  assign accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_dt_sq_r <= dcp_pkg::CFG_RESET;
      busy_r      <= 1'b1;
      vld_r       <= '0;
    end else begin
      busy_r <= 1'b0;
      // valid bits advance with the data, one stage per cycle
      vld_r  <= {vld_r[LATENCY-2:0], accept};
      if (cfg_we) begin
        inv_dt_sq_r <= cfg_wdata;
      end
    end
  end

  // ---------------- stage 1: capture the item ----------------
  dcp_pkg::pos_t [2:0]  s1_a_r;
  dcp_pkg::pos_t [2:0]  s1_b_r;
  logic [POS_W-1:0]     s1_wa_r, s1_wb_r, s1_rest_r, s1_comp_r;
  logic                 s1_fa_r, s1_fb_r;

  always_ff @(posedge clk) begin
    s1_a_r    <= {in_pos_a_z, in_pos_a_y, in_pos_a_x};
    s1_b_r    <= {in_pos_b_z, in_pos_b_y, in_pos_b_x};
    s1_wa_r   <= in_inv_mass_a;
    s1_wb_r   <= in_inv_mass_b;
    s1_fa_r   <= in_fixed_a;
    s1_fb_r   <= in_fixed_b;
    s1_rest_r <= in_rest_length;
    s1_comp_r <= in_compliance;
  end

  // ---------------- stage 2: deltas, alpha, weight sum ----------------
  dcp_pkg::ctx_sq_t              s2_ctx_nxt, s2_ctx_r;
  logic [dcp_pkg::ALPHA_W-1:0]   s2_alpha_r;
  logic [POS_W:0]                s2_wsum_r;

  always_comb begin
    logic [POS_W:0] d;
    s2_ctx_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      d = {s1_b_r[i][POS_W-1], s1_b_r[i]} - {s1_a_r[i][POS_W-1], s1_a_r[i]};
      s2_ctx_nxt.dneg[i] = d[POS_W];
      s2_ctx_nxt.dnz[i]  = |d;
      s2_ctx_nxt.ad[i]   = d[POS_W] ? dcp_pkg::AD_W'(-d) : dcp_pkg::AD_W'(d);
    end
    s2_ctx_nxt.pos_a = s1_a_r;
    s2_ctx_nxt.pos_b = s1_b_r;
    s2_ctx_nxt.wa    = s1_wa_r;
    s2_ctx_nxt.wb    = s1_wb_r;
    s2_ctx_nxt.fa    = s1_fa_r;
    s2_ctx_nxt.fb    = s1_fb_r;
    s2_ctx_nxt.rest  = s1_rest_r;
  end

  always_ff @(posedge clk) begin
    s2_ctx_r   <= s2_ctx_nxt;
    s2_alpha_r <= dcp_pkg::ALPHA_W'(s1_comp_r) * dcp_pkg::ALPHA_W'(inv_dt_sq_r);
    s2_wsum_r  <= {1'b0, s1_wa_r} + {1'b0, s1_wb_r};
  end

  // ---------------- stage 3: squares and denominator ----------------
  dcp_pkg::ctx_sq_t          s3_ctx_nxt, s3_ctx_r;
  logic [dcp_pkg::SQ_W-1:0]  s3_sq_r [3];

  always_comb begin
    s3_ctx_nxt       = s2_ctx_r;
    s3_ctx_nxt.denom = dcp_pkg::DEN_W'(s2_wsum_r) + dcp_pkg::DEN_W'(s2_alpha_r);
    s3_ctx_nxt.wzero = (s2_wsum_r == '0);
  end

  always_ff @(posedge clk) begin
    s3_ctx_r <= s3_ctx_nxt;
    for (int i = 0; i < 3; i++) begin
      s3_sq_r[i] <= dcp_pkg::SQ_W'(s2_ctx_r.ad[i]) * dcp_pkg::SQ_W'(s2_ctx_r.ad[i]);
    end
  end

  // ---------------- stage 4: squared distance ----------------
  dcp_pkg::ctx_sq_t           s4_ctx_r;
  logic [dcp_pkg::SUM_W-1:0]  s4_sum_r;

  always_ff @(posedge clk) begin
    s4_ctx_r <= s3_ctx_r;
    s4_sum_r <= dcp_pkg::SUM_W'(s3_sq_r[0]) + dcp_pkg::SUM_W'(s3_sq_r[1])
              + dcp_pkg::SUM_W'(s3_sq_r[2]);
  end

  // ---------------- square root, context held alongside ----------------
  logic [ROOT_W-1:0]  span;
  dcp_pkg::ctx_sq_t   dl_sq_r [ROOT_W];

  dcp_sqrt_pipe #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk    (clk),
    .rad_i  (s4_sum_r),
    .root_o (span)
  );

  always_ff @(posedge clk) begin
    dl_sq_r[0] <= s4_ctx_r;
    for (int i = 1; i < ROOT_W; i++) begin
      dl_sq_r[i] <= dl_sq_r[i-1];
    end
  end

  // ---------------- stage 5: violation and skip decision ----------------
  dcp_pkg::ctx_sq_t           cs;
  dcp_pkg::ctx_d1_t           s5_ctx_nxt, s5_ctx_r;
  logic [dcp_pkg::ABSC_W-1:0] absc, s5_absc_r;
  logic [ROOT_W:0]            cval;
  logic [POS_W-1:0]           s5_wa_r, s5_wb_r;
  logic [dcp_pkg::DEN_W-1:0]  s5_denom_r;

  assign cs = dl_sq_r[ROOT_W-1];

  always_comb begin
    cval = {1'b0, span} - {2'b00, cs.rest};
    absc = cval[ROOT_W] ? dcp_pkg::ABSC_W'(-cval) : dcp_pkg::ABSC_W'(cval);
    s5_ctx_nxt.pos_a = cs.pos_a;
    s5_ctx_nxt.pos_b = cs.pos_b;
    s5_ctx_nxt.ad    = cs.ad;
    s5_ctx_nxt.dneg  = cs.dneg;
    s5_ctx_nxt.dnz   = cs.dnz;
    s5_ctx_nxt.fa    = cs.fa;
    s5_ctx_nxt.fb    = cs.fb;
    // both pinned, zero distance or zero weight: pass through
    s5_ctx_nxt.skip  = (cs.fa & cs.fb) | (span == '0) | cs.wzero;
    s5_ctx_nxt.cneg  = cval[ROOT_W];
    s5_ctx_nxt.cnz   = |cval;
    s5_ctx_nxt.span  = span;
    if (s5_ctx_nxt.skip) begin
      s5_ctx_nxt.viol = '0;
    end else if (absc[dcp_pkg::ABSC_W-1]) begin
      s5_ctx_nxt.viol = '1;
    end else begin
      s5_ctx_nxt.viol = absc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s5_ctx_r   <= s5_ctx_nxt;
    s5_absc_r  <= absc;
    s5_wa_r    <= cs.wa;
    s5_wb_r    <= cs.wb;
    s5_denom_r <= cs.denom;
  end

  // ---------------- stage 6: w * |C| ----------------
  dcp_pkg::ctx_d1_t           s6_ctx_r;
  logic [NUM_W-1:0]           s6_prod_a_r, s6_prod_b_r;
  logic [dcp_pkg::DEN_W-1:0]  s6_denom_r;

  always_ff @(posedge clk) begin
    s6_ctx_r    <= s5_ctx_r;
    s6_denom_r  <= s5_denom_r;
    s6_prod_a_r <= NUM_W'(s5_wa_r) * NUM_W'(s5_absc_r);
    s6_prod_b_r <= NUM_W'(s5_wb_r) * NUM_W'(s5_absc_r);
  end

  // ---------------- lambda division: m = w * |C| / denom ----------------
  logic [QUO_W-1:0]  ma, mb;
  dcp_pkg::ctx_d1_t  dl_d1_r [QUO_W];

  dcp_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (dcp_pkg::DEN_W),
    .QUO_W (QUO_W)
  ) u_div_ma (
    .clk   (clk),
    .num_i (s6_prod_a_r),
    .den_i (s6_denom_r),
    .quo_o (ma)
  );

  dcp_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (dcp_pkg::DEN_W),
    .QUO_W (QUO_W)
  ) u_div_mb (
    .clk   (clk),
    .num_i (s6_prod_b_r),
    .den_i (s6_denom_r),
    .quo_o (mb)
  );

  always_ff @(posedge clk) begin
    dl_d1_r[0] <= s6_ctx_r;
    for (int i = 1; i < QUO_W; i++) begin
      dl_d1_r[i] <= dl_d1_r[i-1];
    end
  end

  // ---------------- stage 7: m * |d_axis| ----------------
  dcp_pkg::ctx_d1_t   c1;
  dcp_pkg::ctx_d2_t   s7_ctx_r;
  logic [ROOT_W-1:0]  s7_dist_r;
  logic [NUM_W-1:0]   s7_pa_r [3];
  logic [NUM_W-1:0]   s7_pb_r [3];

  assign c1 = dl_d1_r[QUO_W-1];

  always_ff @(posedge clk) begin
    s7_ctx_r.pos_a <= c1.pos_a;
    s7_ctx_r.pos_b <= c1.pos_b;
    s7_ctx_r.dneg  <= c1.dneg;
    s7_ctx_r.dnz   <= c1.dnz;
    s7_ctx_r.fa    <= c1.fa;
    s7_ctx_r.fb    <= c1.fb;
    s7_ctx_r.skip  <= c1.skip;
    s7_ctx_r.cneg  <= c1.cneg;
    s7_ctx_r.cnz   <= c1.cnz;
    s7_ctx_r.viol  <= c1.viol;
    s7_dist_r      <= c1.span;
    for (int i = 0; i < 3; i++) begin
      s7_pa_r[i] <= NUM_W'(ma) * NUM_W'(c1.ad[i]);
      s7_pb_r[i] <= NUM_W'(mb) * NUM_W'(c1.ad[i]);
    end
  end

  // ---------------- per-axis division: s = m * |d| / distance ----------------
  logic [QUO_W-1:0]  sa [3];
  logic [QUO_W-1:0]  sb [3];
  dcp_pkg::ctx_d2_t  dl_d2_r [QUO_W];

  for (genvar g = 0; g < 3; g++) begin : g_axis
    dcp_div_pipe #(
      .NUM_W (NUM_W),
      .DEN_W (ROOT_W),
      .QUO_W (QUO_W)
    ) u_div_sa (
      .clk   (clk),
      .num_i (s7_pa_r[g]),
      .den_i (s7_dist_r),
      .quo_o (sa[g])
    );

    dcp_div_pipe #(
      .NUM_W (NUM_W),
      .DEN_W (ROOT_W),
      .QUO_W (QUO_W)
    ) u_div_sb (
      .clk   (clk),
      .num_i (s7_pb_r[g]),
      .den_i (s7_dist_r),
      .quo_o (sb[g])
    );
  end

  always_ff @(posedge clk) begin
    dl_d2_r[0] <= s7_ctx_r;
    for (int i = 1; i < QUO_W; i++) begin
      dl_d2_r[i] <= dl_d2_r[i-1];
    end
  end

  // ---------------- stage 8: apply corrections, saturate ----------------
  dcp_pkg::ctx_d2_t     c2;
  dcp_pkg::pos_t [2:0]  new_a, new_b;
  dcp_pkg::pos_t [2:0]  out_a_r, out_b_r;
  logic [POS_W-1:0]     out_viol_r;

  assign c2 = dl_d2_r[QUO_W-1];

  always_comb begin
    logic              toward;
    logic [POS_W+2:0]  ea, eb, esa, esb;
    for (int i = 0; i < 3; i++) begin
      // first particle moves in the positive direction on this axis when C and d share a sign
      toward = (c2.cneg == c2.dneg[i]) & c2.cnz & c2.dnz[i];
      ea  = {{3{c2.pos_a[i][POS_W-1]}}, c2.pos_a[i]};
      eb  = {{3{c2.pos_b[i][POS_W-1]}}, c2.pos_b[i]};
      esa = {2'b00, sa[i]};
      esb = {2'b00, sb[i]};
      if (c2.skip || c2.fa) begin
        new_a[i] = c2.pos_a[i];
      end else begin
        new_a[i] = sat_pos(toward ? ea + esa : ea - esa);
      end
      if (c2.skip || c2.fb) begin
        new_b[i] = c2.pos_b[i];
      end else begin
        new_b[i] = sat_pos(toward ? eb - esb : eb + esb);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_a_r    <= new_a;
    out_b_r    <= new_b;
    out_viol_r <= c2.viol;
  end

  // ---------------- ports ----------------
  assign busy          = busy_r;
  assign out_valid     = vld_r[LATENCY-1];
  assign out_new_a_x   = out_a_r[0];
  assign out_new_a_y   = out_a_r[1];
  assign out_new_a_z   = out_a_r[2];
  assign out_new_b_x   = out_b_r[0];
  assign out_new_b_y   = out_b_r[1];
  assign out_new_b_z   = out_b_r[2];
  assign out_violation = out_viol_r;

endmodule
`default_nettype wire

[src/dcp_checker.sv]
// Port-level checker of the constraint projection block, bound to the top level.
`default_nettype none
`include "distance_constraint_projection_top_defines.svh"
module dcp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_pos_a_x,
  input logic signed [31:0] in_pos_a_y,
  input logic signed [31:0] in_pos_b_z,
  input logic               in_fixed_a,
  input logic               in_fixed_b,
  input logic               out_valid,
  input logic signed [31:0] out_new_a_x,
  input logic signed [31:0] out_new_a_y,
  input logic signed [31:0] out_new_b_z,
  input logic [31:0]        out_violation
);

  `DCP_ASSERT_NEXT(a_busy_clear, clk, rst_n, 1'b1, !busy, "busy high out of reset")
  `DCP_ASSERT_SAME(a_item_out, clk, rst_n, start && !busy, ##(dcp_pkg::LATENCY) out_valid, "accepted item gave no result")
  `DCP_ASSERT_SAME(a_no_ghost, clk, rst_n, out_valid, $past(start && !busy, dcp_pkg::LATENCY), "result without an accepted item")
  `DCP_ASSERT_SAME(a_both_pinned, clk, rst_n, out_valid && $past(in_fixed_a && in_fixed_b, dcp_pkg::LATENCY), out_violation == 32'd0 && out_new_a_x == $past(in_pos_a_x, dcp_pkg::LATENCY) && out_new_b_z == $past(in_pos_b_z, dcp_pkg::LATENCY), "pinned pair moved")
  `DCP_ASSERT_SAME(a_pin_a, clk, rst_n, out_valid && $past(in_fixed_a, dcp_pkg::LATENCY), out_new_a_y == $past(in_pos_a_y, dcp_pkg::LATENCY), "pinned particle moved")

endmodule

bind distance_constraint_projection_top dcp_checker u_dcp_checker (.*);
`default_nettype wire
